FILE: rtl/core/solar_collector_flow_limiter_core_assert.svh
// Assertion macros used by the flow limiter port checker.
`ifndef SOLAR_COLLECTOR_FLOW_LIMITER_CORE_ASSERT_SVH
`define SOLAR_COLLECTOR_FLOW_LIMITER_CORE_ASSERT_SVH

// Same-cycle implication, disabled while en is low.
`define SCFL_ASSERT_IMP(lbl, clk, en, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(en)) (ante) |-> (cons)) \
        else $error("scfl check failed");

// Next-cycle implication, disabled while en is low.
`define SCFL_ASSERT_NXT(lbl, clk, en, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(en)) (ante) |=> (cons)) \
        else $error("scfl check failed");

`endif

FILE: rtl/core/scfl_pkg.sv
// Shared constants and types of the solar collector flow limiter.
`default_nettype none
package scfl_pkg;
    localparam int TABLE_DEPTH = 16384;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);
    localparam int IDX_W       = 16;
    localparam int LEN_W       = 15;
    localparam int IRR_W       = 12;
    localparam int GAIN_W      = 21;
    localparam int CP_W        = 16;
    localparam int FLOW_W      = 32;
    localparam int TEMP_W      = 16;
    localparam int RISE_W      = 15;
    localparam int HEAT_W      = 24;
    localparam int CFG_W       = 32;
    localparam int CFG_IDX_W   = 3;

    localparam int MOD_STEPS   = IDX_W;
    localparam int MOD_LAT     = MOD_STEPS + 1;

    localparam int QUO_W       = 32;
    localparam int NUM_W       = 47;
    localparam int DEN_W       = 48;
    localparam int REM_W       = DEN_W + 1;
    localparam int DIV_LAT     = QUO_W + 1;

    localparam int HEAT_MUL    = 100;            // 6553600 = 100 << 16
    localparam int HEAT_SH     = 16;
    localparam int V_W         = NUM_W - HEAT_SH;
    localparam logic [31:0] RECIP_M = 32'd2748779070;  // ceil(2^38 / 100)
    localparam int RECIP_SH    = 38;

    localparam logic signed [TEMP_W-1:0] NO_LIMIT = 16'sd32767;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TABLE_LENGTH,
        CFG_COLLECTOR_GAIN,
        CFG_TURN_ON,
        CFG_HEAT_CAPACITY,
        CFG_NOMINAL_FLOW,
        CFG_MAXIMUM_FLOW,
        CFG_OUTLET_LIMIT,
        CFG_RISE_LIMIT
    } t_cfg_idx;

    typedef enum logic [1:0] {
        MODE_DIS,
        MODE_OFF,
        MODE_HOT,
        MODE_RUN
    } t_mode;

    typedef struct packed {
        logic                     vld;
        logic                     step;
        logic [IDX_W-1:0]         idx;
        logic [IRR_W-1:0]         smp;
        logic signed [TEMP_W-1:0] tin;
        logic [IRR_W-1:0]         irr;
        t_mode                    mode;
        logic [HEAT_W-1:0]        raw;
        logic [NUM_W-1:0]         qs;
        logic [15:0]              head;
        logic [FLOW_W-1:0]        flow;
        logic [DEN_W-1:0]         fc;
        logic [15:0]              dt;
        logic [62:0]              pr;
        logic [63:0]              ph;
        logic [V_W-1:0]           v;
        logic                     cut;
    } t_ctx;

    typedef struct packed {
        logic signed [TEMP_W-1:0] outlet;
        logic [FLOW_W-1:0]        flow;
        logic [HEAT_W-1:0]        use_heat;
        logic [HEAT_W-1:0]        raw;
        logic [IRR_W-1:0]         irr;
        logic                     on;
    } t_res;
endpackage
`default_nettype wire

FILE: rtl/core/scfl_ram.sv
// Generic simple dual-port RAM with registered read.
`default_nettype none
module scfl_ram #(
    parameter int WIDTH = 12,
    parameter int DEPTH = 16384,
    localparam int AW   = $clog2(DEPTH)
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [0:DEPTH-1];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule
`default_nettype wire

FILE: rtl/core/scfl_mod.sv
// Pipelined hour-modulo-length unit, one remainder bit per stage.
`default_nettype none
module scfl_mod (
    input  wire logic                          i_clk,
    input  wire logic                          i_en,
    input  wire logic [scfl_pkg::IDX_W-1:0]    i_num,
    input  wire logic [scfl_pkg::LEN_W-1:0]    i_den,
    output logic      [scfl_pkg::ADDR_W-1:0]   o_rem
);
    localparam int W = scfl_pkg::IDX_W;
    localparam int N = scfl_pkg::MOD_STEPS;

    logic [W-1:0] r_rem [0:N];
    logic [W-1:0] r_num [0:N];
    logic [W-1:0] n_rem [0:N-1];
    logic [W:0]   t     [0:N-1];
    logic [W:0]   den_x;

    assign den_x = (W+1)'(i_den);

    always_comb begin
        for (int k = 0; k < N; k++) begin
            t[k] = {r_rem[k], r_num[k][W-1]};
            if (t[k] >= den_x) begin
                n_rem[k] = W'(t[k] - den_x);
            end else begin
                n_rem[k] = t[k][W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= '0;
            r_num[0] <= i_num;
            for (int k = 0; k < N; k++) begin
                r_rem[k+1] <= n_rem[k];
                r_num[k+1] <= {r_num[k][W-2:0], 1'b0};
            end
        end
    end

    assign o_rem = r_rem[N][scfl_pkg::ADDR_W-1:0];
endmodule
`default_nettype wire

FILE: rtl/core/scfl_div.sv
// Pipelined restoring divider, one quotient bit per stage, saturating quotient.
`default_nettype none
module scfl_div (
    input  wire logic                        i_clk,
    input  wire logic                        i_en,
    input  wire logic [scfl_pkg::NUM_W-1:0]  i_num,
    input  wire logic [scfl_pkg::DEN_W-1:0]  i_den,
    output logic      [scfl_pkg::QUO_W-1:0]  o_quo,
    output logic                             o_rem_nz
);
    localparam int QW = scfl_pkg::QUO_W;
    localparam int RW = scfl_pkg::REM_W;
    localparam int DW = scfl_pkg::DEN_W;
    localparam int NW = scfl_pkg::NUM_W;

    logic [RW-1:0] r_rem [0:QW];
    logic [QW-1:0] r_low [0:QW];
    logic [QW-1:0] r_quo [0:QW];
    logic [DW-1:0] r_den [0:QW];
    logic          r_sat [0:QW];
    logic [RW-1:0] t     [0:QW-1];
    logic [RW-1:0] n_rem [0:QW-1];
    logic          ge    [0:QW-1];

    always_comb begin
        for (int k = 0; k < QW; k++) begin
            t[k]  = {r_rem[k][RW-2:0], r_low[k][QW-1]};
            ge[k] = t[k] >= RW'(r_den[k]);
            n_rem[k] = ge[k] ? (t[k] - RW'(r_den[k])) : t[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            // upper part at or above the divisor: quotient needs more than QW bits
            r_rem[0] <= RW'(i_num[NW-1:QW]);
            r_low[0] <= i_num[QW-1:0];
            r_quo[0] <= '0;
            r_den[0] <= i_den;
            r_sat[0] <= DW'(i_num[NW-1:QW]) >= i_den;
            for (int k = 0; k < QW; k++) begin
                r_rem[k+1] <= n_rem[k];
                r_low[k+1] <= {r_low[k][QW-2:0], 1'b0};
                r_quo[k+1] <= {r_quo[k][QW-2:0], ge[k]};
                r_den[k+1] <= r_den[k];
                r_sat[k+1] <= r_sat[k];
            end
        end
    end

    assign o_quo    = r_sat[QW] ? '1 : r_quo[QW];
    assign o_rem_nz = r_rem[QW] != '0;
endmodule
`default_nettype wire

FILE: rtl/core/solar_collector_flow_limiter_core.sv
// Top level of the solar collector flow limiter.
// A write word (tuser 0) stores one irradiance sample into the hour table;
// a step word (tuser 1) returns one result word. The core takes one word
// per clock while the skid buffer is empty. The pipeline is built from the
// 17-stage hour modulo pipeline, the table read and two 33-stage
// bit-per-stage dividers (required flow, then temperature rise), plus a few
// multiply stages. All words travel in order through one pipeline that
// stalls as a whole; table writes are done at the same stage as table
// reads, so reads and writes to the table keep word order without
// forwarding. An output register plus a one-word skid buffer keep the input
// open while a finished result waits. Table contents are undefined until
// written. Configuration writes are to be done while the core is idle.
`default_nettype none
module solar_collector_flow_limiter_core (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    // slave side
    input  wire logic          s_axis_tvalid,
    output logic               s_axis_tready,
    // [15:0] index, [27:16] irradiance_sample, [43:28] inlet_temp, [47:44] zero
    input  wire logic [47:0]   s_axis_tdata,
    // [0] action
    input  wire logic          s_axis_tuser,
    // master side
    output logic               m_axis_tvalid,
    input  wire logic          m_axis_tready,
    // [11:0] irradiance, [35:12] raw_heat, [59:36] useful_heat,
    // [91:60] flow_rate, [107:92] outlet_temp, [111:108] zero
    output logic      [111:0]  m_axis_tdata,
    // [0] pump_on
    output logic               m_axis_tuser,
    // configuration write port
    input  wire logic          i_cfg_we,
    input  wire logic [scfl_pkg::CFG_IDX_W-1:0] i_cfg_addr,
    input  wire logic [scfl_pkg::CFG_W-1:0]     i_cfg_data
);
    // ---------------- configuration registers ----------------
    logic [scfl_pkg::LEN_W-1:0]         r_table_length;
    logic [scfl_pkg::GAIN_W-1:0]        r_gain;
    logic [scfl_pkg::IRR_W-1:0]         r_turn_on;
    logic [scfl_pkg::CP_W-1:0]          r_cp;
    logic [scfl_pkg::FLOW_W-1:0]        r_nom;
    logic [scfl_pkg::FLOW_W-1:0]        r_max;
    logic signed [scfl_pkg::TEMP_W-1:0] r_tmax;
    logic [scfl_pkg::RISE_W-1:0]        r_rise;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_table_length <= '0;
            r_gain         <= '0;
            r_turn_on      <= '0;
            r_cp           <= 16'd4186;
            r_nom          <= 32'd65536;
            r_max          <= 32'd65536;
            r_tmax         <= scfl_pkg::NO_LIMIT;
            r_rise         <= '0;
        end else if (i_cfg_we) begin
            case (scfl_pkg::t_cfg_idx'(i_cfg_addr))
                scfl_pkg::CFG_TABLE_LENGTH:   r_table_length <= i_cfg_data[14:0];
                scfl_pkg::CFG_COLLECTOR_GAIN: r_gain         <= i_cfg_data[20:0];
                scfl_pkg::CFG_TURN_ON:        r_turn_on      <= i_cfg_data[11:0];
                scfl_pkg::CFG_HEAT_CAPACITY:  r_cp           <= i_cfg_data[15:0];
                scfl_pkg::CFG_NOMINAL_FLOW:   r_nom          <= i_cfg_data;
                scfl_pkg::CFG_MAXIMUM_FLOW:   r_max          <= i_cfg_data;
                scfl_pkg::CFG_OUTLET_LIMIT:   r_tmax         <= signed'(i_cfg_data[15:0]);
                scfl_pkg::CFG_RISE_LIMIT:     r_rise         <= i_cfg_data[14:0];
                default: ;
            endcase
        end
    end

    // effective settings (zero cp / nominal read as 1, max at least nominal)
    logic [scfl_pkg::LEN_W-1:0]  len_eff;
    logic [scfl_pkg::CP_W-1:0]   cp_eff;
    logic [scfl_pkg::FLOW_W-1:0] nom_eff;
    logic [scfl_pkg::FLOW_W-1:0] max_eff;
    logic                        limit_on;

    always_comb begin
        len_eff  = (32'(r_table_length) > scfl_pkg::TABLE_DEPTH)
                 ? scfl_pkg::LEN_W'(scfl_pkg::TABLE_DEPTH) : r_table_length;
        cp_eff   = (r_cp == '0) ? 16'd1 : r_cp;
        nom_eff  = (r_nom == '0) ? 32'd1 : r_nom;
        max_eff  = (r_max < nom_eff) ? nom_eff : r_max;
        limit_on = r_tmax != scfl_pkg::NO_LIMIT;
    end

    // ---------------- pipeline control ----------------
    logic en;
    logic r_skid_vld;

    assign en            = !r_skid_vld;
    assign s_axis_tready = en;

    scfl_pkg::t_ctx n_in;
    always_comb begin
        n_in      = '0;
        n_in.vld  = s_axis_tvalid;
        n_in.step = s_axis_tuser;
        n_in.idx  = s_axis_tdata[15:0];
        n_in.smp  = s_axis_tdata[27:16];
        n_in.tin  = signed'(s_axis_tdata[43:28]);
    end

    // ---------------- hour modulo ----------------
    logic [scfl_pkg::ADDR_W-1:0] mod_rem;

    scfl_mod u_mod (
        .i_clk (i_clk),
        .i_en  (en),
        .i_num (s_axis_tdata[15:0]),
        .i_den (len_eff),
        .o_rem (mod_rem)
    );

    scfl_pkg::t_ctx r_md [0:scfl_pkg::MOD_LAT-1];
    scfl_pkg::t_ctx md_last;
    assign md_last = r_md[scfl_pkg::MOD_LAT-1];

    // ---------------- table access ----------------
    logic                       ram_we;
    logic [scfl_pkg::IRR_W-1:0] ram_rdata;

    assign ram_we = en && md_last.vld && !md_last.step
                 && (32'(md_last.idx) < scfl_pkg::TABLE_DEPTH);

    scfl_ram #(
        .WIDTH (scfl_pkg::IRR_W),
        .DEPTH (scfl_pkg::TABLE_DEPTH)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (md_last.idx[scfl_pkg::ADDR_W-1:0]),
        .i_wdata (md_last.smp),
        .i_re    (en),
        .i_raddr (mod_rem),
        .o_rdata (ram_rdata)
    );

    // write words retire here
    scfl_pkg::t_ctx n_rd, r_rd;
    always_comb begin
        n_rd     = md_last;
        n_rd.vld = md_last.vld && md_last.step;
    end

    // ---------------- irradiance and raw heat ----------------
    scfl_pkg::t_ctx n_ir, r_ir;
    logic [32:0] irr_prod;
    logic [24:0] irr_sh;

    always_comb begin
        n_ir     = r_rd;
        irr_prod = 33'(ram_rdata) * 33'(r_gain);
        irr_sh   = irr_prod[32:8];
        n_ir.raw = (irr_sh > 25'hFFFFFF) ? '1 : irr_sh[23:0];
        if (len_eff == '0) begin
            n_ir.irr  = '0;
            n_ir.mode = scfl_pkg::MODE_DIS;
        end else begin
            n_ir.irr = ram_rdata;
            if (r_gain == '0 || ram_rdata < r_turn_on) begin
                n_ir.mode = scfl_pkg::MODE_OFF;
            end else if (limit_on && r_rd.tin >= r_tmax) begin
                n_ir.mode = scfl_pkg::MODE_HOT;
            end else begin
                n_ir.mode = scfl_pkg::MODE_RUN;
            end
        end
    end

    // ---------------- scaled heat and flow divisors ----------------
    scfl_pkg::t_ctx n_q, r_q;
    logic [30:0]         raw100;
    logic signed [16:0]  head_diff;
    logic [31:0]         n_d1, n_d2, r_d1, r_d2;

    always_comb begin
        n_q       = r_ir;
        raw100    = 31'(r_ir.raw) * 31'(scfl_pkg::HEAT_MUL);
        n_q.qs    = {raw100, 16'b0};
        head_diff = 17'(r_tmax) - 17'(r_ir.tin);
        n_q.head  = limit_on ? head_diff[15:0] : 16'd0;
        n_d1      = 32'(cp_eff) * 32'(n_q.head);
        n_d2      = 32'(cp_eff) * 32'(r_rise);
    end

    logic [scfl_pkg::QUO_W-1:0] q1, q2, qdt;
    logic                       nz1, nz2, nzdt;

    scfl_div u_div_head (
        .i_clk    (i_clk),
        .i_en     (en),
        .i_num    (r_q.qs),
        .i_den    (scfl_pkg::DEN_W'(r_d1)),
        .o_quo    (q1),
        .o_rem_nz (nz1)
    );

    scfl_div u_div_rise (
        .i_clk    (i_clk),
        .i_en     (en),
        .i_num    (r_q.qs),
        .i_den    (scfl_pkg::DEN_W'(r_d2)),
        .o_quo    (q2),
        .o_rem_nz (nz2)
    );

    scfl_pkg::t_ctx r_dq [0:scfl_pkg::DIV_LAT-1];

    // ---------------- flow selection ----------------
    scfl_pkg::t_ctx n_f, r_f, dq_last;
    logic [31:0] need1, need2, req;

    always_comb begin
        dq_last = r_dq[scfl_pkg::DIV_LAT-1];
        n_f     = dq_last;
        // ceiling; a saturated quotient stays saturated
        need1   = q1 + 32'(nz1 && q1 != '1);
        need2   = q2 + 32'(nz2 && q2 != '1);
        req     = nom_eff;
        if (limit_on && need1 > req) begin
            req = need1;
        end
        if (r_rise != '0 && need2 > req) begin
            req = need2;
        end
        if (dq_last.raw != '0) begin
            n_f.flow = (req < max_eff) ? req : max_eff;
        end else begin
            n_f.flow = nom_eff;
        end
    end

    scfl_pkg::t_ctx n_p, r_p;
    always_comb begin
        n_p    = r_f;
        n_p.fc = 48'(r_f.flow) * 48'(cp_eff);
    end

    // ---------------- temperature rise ----------------
    scfl_div u_div_dt (
        .i_clk    (i_clk),
        .i_en     (en),
        .i_num    (r_p.qs),
        .i_den    (r_p.fc),
        .o_quo    (qdt),
        .o_rem_nz (nzdt)
    );

    scfl_pkg::t_ctx r_dt [0:scfl_pkg::DIV_LAT-1];

    scfl_pkg::t_ctx n_x1, r_x1, dt_last;
    always_comb begin
        dt_last = r_dt[scfl_pkg::DIV_LAT-1];
        n_x1    = dt_last;
        n_x1.dt = (qdt > 32'd65535) ? 16'hFFFF : qdt[15:0];
        n_x1.pr = 63'(r_rise) * 63'(dt_last.fc);
        n_x1.ph = 64'(dt_last.head) * 64'(dt_last.fc);
    end

    // limit checks; a cut product is below qs, so it fits V_W bits after >> 16
    scfl_pkg::t_ctx n_x2, r_x2;
    logic capped, over;
    always_comb begin
        n_x2   = r_x1;
        capped = (r_rise != '0) && (64'(r_x1.qs) > 64'(r_x1.pr));
        over   = limit_on && (capped ? (16'(r_rise) > r_x1.head)
                                     : (64'(r_x1.qs) > r_x1.ph));
        n_x2.cut = 1'b0;
        n_x2.v   = '0;
        if (over) begin
            n_x2.dt  = r_x1.head;
            n_x2.v   = r_x1.ph[scfl_pkg::NUM_W-1:scfl_pkg::HEAT_SH];
            n_x2.cut = 1'b1;
        end else if (capped) begin
            n_x2.dt  = 16'(r_rise);
            n_x2.v   = r_x1.pr[scfl_pkg::NUM_W-1:scfl_pkg::HEAT_SH];
            n_x2.cut = 1'b1;
        end
    end

    // ---------------- result word ----------------
    scfl_pkg::t_res     n_res;
    logic [62:0]        use_prod;
    logic [23:0]        use_heat;
    logic signed [17:0] tsum;
    logic signed [15:0] tout;

    always_comb begin
        use_prod = 63'(r_x2.v) * 63'(scfl_pkg::RECIP_M);
        use_heat = r_x2.cut
                 ? use_prod[scfl_pkg::RECIP_SH+scfl_pkg::HEAT_W-1:scfl_pkg::RECIP_SH]
                 : r_x2.raw;
        tsum     = 18'(r_x2.tin) + signed'({2'b00, r_x2.dt});
        tout     = (tsum > 18'sd32767) ? 16'sd32767 : tsum[15:0];
        n_res    = '0;
        n_res.outlet = r_x2.tin;
        case (r_x2.mode)
            scfl_pkg::MODE_DIS: ;
            scfl_pkg::MODE_OFF: begin
                n_res.irr = r_x2.irr;
            end
            scfl_pkg::MODE_HOT: begin
                n_res.irr = r_x2.irr;
                n_res.raw = r_x2.raw;
            end
            scfl_pkg::MODE_RUN: begin
                n_res.irr      = r_x2.irr;
                n_res.raw      = r_x2.raw;
                n_res.use_heat = use_heat;
                n_res.flow     = r_x2.flow;
                n_res.outlet   = tout;
                n_res.on       = use_heat != '0;
            end
            default: ;
        endcase
    end

    // ---------------- pipeline registers ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < scfl_pkg::MOD_LAT; k++) begin
                r_md[k].vld <= 1'b0;
            end
            for (int k = 0; k < scfl_pkg::DIV_LAT; k++) begin
                r_dq[k].vld <= 1'b0;
                r_dt[k].vld <= 1'b0;
            end
            r_rd.vld <= 1'b0;
            r_ir.vld <= 1'b0;
            r_q.vld  <= 1'b0;
            r_f.vld  <= 1'b0;
            r_p.vld  <= 1'b0;
            r_x1.vld <= 1'b0;
            r_x2.vld <= 1'b0;
        end else if (en) begin
            r_md[0] <= n_in;
            for (int k = 0; k < scfl_pkg::MOD_LAT - 1; k++) begin
                r_md[k+1] <= r_md[k];
            end
            r_rd <= n_rd;
            r_ir <= n_ir;
            r_q  <= n_q;
            r_d1 <= n_d1;
            r_d2 <= n_d2;
            r_dq[0] <= r_q;
            for (int k = 0; k < scfl_pkg::DIV_LAT - 1; k++) begin
                r_dq[k+1] <= r_dq[k];
                r_dt[k+1] <= r_dt[k];
            end
            r_f     <= n_f;
            r_p     <= n_p;
            r_dt[0] <= r_p;
            r_x1    <= n_x1;
            r_x2    <= n_x2;
        end
    end

    // ---------------- output register and skid buffer ----------------
    scfl_pkg::t_res r_out, r_skid;
    logic           r_out_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld  <= 1'b0;
            r_skid_vld <= 1'b0;
        end else if (r_out_vld && !m_axis_tready) begin
            // output held; park a new result in the skid slot
            if (!r_skid_vld && r_x2.vld) begin
                r_skid     <= n_res;
                r_skid_vld <= 1'b1;
            end
        end else if (r_skid_vld) begin
            r_out      <= r_skid;
            r_out_vld  <= 1'b1;
            r_skid_vld <= 1'b0;
        end else begin
            r_out     <= n_res;
            r_out_vld <= r_x2.vld;
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = {4'b0000, r_out.outlet, r_out.flow, r_out.use_heat,
                            r_out.raw, r_out.irr};
    assign m_axis_tuser  = r_out.on;
endmodule
`default_nettype wire

FILE: rtl/core/scfl_chk.sv
// Port-level checker for the flow limiter, bound to the top level.
`default_nettype none
`include "solar_collector_flow_limiter_core_assert.svh"
module scfl_chk (
    input wire logic         i_clk,
    input wire logic         i_rst_n,
    input wire logic         m_axis_tvalid,
    input wire logic         m_axis_tready,
    input wire logic [111:0] m_axis_tdata,
    input wire logic         m_axis_tuser
);
    // no result word right after reset
    `SCFL_ASSERT_NXT(a_rst_idle, i_clk, 1'b1, !i_rst_n, !m_axis_tvalid)

    // stalled word holds
    `SCFL_ASSERT_NXT(a_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready,
        m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))

    // pump on needs heat and flow
    `SCFL_ASSERT_IMP(a_pump, i_clk, i_rst_n, m_axis_tvalid && m_axis_tuser,
        m_axis_tdata[59:36] != 24'd0 && m_axis_tdata[91:60] != 32'd0)

    // limiting never adds heat
    `SCFL_ASSERT_IMP(a_cut, i_clk, i_rst_n, m_axis_tvalid,
        m_axis_tdata[59:36] <= m_axis_tdata[35:12])
endmodule

bind solar_collector_flow_limiter_core scfl_chk u_scfl_chk (.*);
`default_nettype wire

FILE: tb/scfl_checker.sv
// Checker for the solar collector flow limiter: predicts step results and compares them.
`timescale 1ns / 100ps
`default_nettype none
module scfl_checker (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         s_axis_tvalid,
    input  wire logic         s_axis_tready,
    input  wire logic [47:0]  s_axis_tdata,
    input  wire logic         s_axis_tuser,
    input  wire logic         m_axis_tvalid,
    input  wire logic         m_axis_tready,
    input  wire logic [111:0] m_axis_tdata,
    input  wire logic         m_axis_tuser,
    input  wire logic         i_cfg_we,
    input  wire logic [scfl_pkg::CFG_IDX_W-1:0] i_cfg_addr,
    input  wire logic [scfl_pkg::CFG_W-1:0]     i_cfg_data,
    output int                o_errors,
    output int                o_pending
);
    localparam longint unsigned SCALE = 64'd6553600;

    typedef struct packed {
        logic [111:0] data;
        logic         on;
    } t_step_res;

    logic [scfl_pkg::IRR_W-1:0] irr_mem [scfl_pkg::TABLE_DEPTH];
    logic [14:0] len_r;
    logic [20:0] gain_r;
    logic [11:0] turn_on_r;
    logic [15:0] cp_r;
    logic [31:0] nom_r, max_r;
    logic signed [15:0] tmax_r;
    logic [14:0] rise_r;
    t_step_res expected_q[$];

    assign o_pending = expected_q.size();

    function automatic t_step_res pack_res(logic [11:0] irr, logic [23:0] raw,
                                           logic [23:0] use_h, logic [31:0] flow,
                                           logic signed [15:0] tout, logic on);
        t_step_res r;
        r.data = {4'd0, tout, flow, use_h, raw, irr};
        r.on = on;
        return r;
    endfunction

    function automatic longint unsigned cdiv(longint unsigned a, longint unsigned b);
        return (a + b - 1) / b;
    endfunction

    function automatic t_step_res predict_step(logic [15:0] hour, logic signed [15:0] tin);
        int unsigned len;
        logic [11:0] irr;
        longint unsigned raw, cp, nom, mx, rise, head, qs, flow, req, fc, use_h, dt;
        bit lim, capped;
        int tout;
        if (len_r == 0) return pack_res(0, 0, 0, 0, tin, 0);
        len = (len_r > scfl_pkg::TABLE_DEPTH) ? scfl_pkg::TABLE_DEPTH : len_r;
        irr = irr_mem[hour % len];
        if (gain_r == 0 || irr < turn_on_r) return pack_res(irr, 0, 0, 0, tin, 0);
        raw = (longint'(irr) * gain_r) >> 8;
        if (raw > 24'hFFFFFF) raw = 24'hFFFFFF;
        lim = (tmax_r != 16'sd32767);
        if (lim && tin >= tmax_r) return pack_res(irr, raw, 0, 0, tin, 0);
        cp = cp_r ? cp_r : 1;
        nom = nom_r ? nom_r : 1;
        mx = (max_r < nom) ? nom : max_r;
        rise = rise_r;
        head = lim ? longint'(int'(tmax_r) - int'(tin)) : 0;
        qs = raw * SCALE;
        flow = nom;
        if (raw > 0) begin
            req = nom;
            if (lim && cdiv(qs, cp * head) > req) req = cdiv(qs, cp * head);
            if (rise > 0 && cdiv(qs, cp * rise) > req) req = cdiv(qs, cp * rise);
            if (req > 64'hFFFFFFFF) req = 64'hFFFFFFFF;
            flow = (req < mx) ? req : mx;
        end
        fc = flow * cp;
        use_h = raw;
        dt = qs / fc;
        capped = 0;
        if (rise > 0 && qs > rise * fc) begin
            dt = rise;
            use_h = fc * rise / SCALE;
            capped = 1;
        end
        if (lim && (capped ? (rise > head) : (qs > head * fc))) begin
            dt = head;
            use_h = fc * head / SCALE;
        end
        if (dt > 65535) dt = 65535;
        tout = int'(tin) + int'(dt);
        if (tout > 32767) tout = 32767;
        return pack_res(irr, raw, use_h, flow, tout, use_h > 0);
    endfunction

    always @(posedge i_clk) begin
        t_step_res got, want, pred;
        if (!i_rst_n) begin
            len_r <= 0; gain_r <= 0; turn_on_r <= 0; cp_r <= 16'd4186;
            nom_r <= 32'd65536; max_r <= 32'd65536; tmax_r <= 16'sd32767; rise_r <= 0;
            o_errors <= 0;
        end else begin
            if (i_cfg_we) begin
                case (scfl_pkg::t_cfg_idx'(i_cfg_addr))
                    scfl_pkg::CFG_TABLE_LENGTH:   len_r <= i_cfg_data[14:0];
                    scfl_pkg::CFG_COLLECTOR_GAIN: gain_r <= i_cfg_data[20:0];
                    scfl_pkg::CFG_TURN_ON:        turn_on_r <= i_cfg_data[11:0];
                    scfl_pkg::CFG_HEAT_CAPACITY:  cp_r <= i_cfg_data[15:0];
                    scfl_pkg::CFG_NOMINAL_FLOW:   nom_r <= i_cfg_data;
                    scfl_pkg::CFG_MAXIMUM_FLOW:   max_r <= i_cfg_data;
                    scfl_pkg::CFG_OUTLET_LIMIT:   tmax_r <= i_cfg_data[15:0];
                    scfl_pkg::CFG_RISE_LIMIT:     rise_r <= i_cfg_data[14:0];
                    default: ;
                endcase
            end
            if (s_axis_tvalid && s_axis_tready) begin
                if (s_axis_tuser) begin
                    pred = predict_step(s_axis_tdata[15:0], s_axis_tdata[43:28]);
                    expected_q = {expected_q, pred};
                end else if (s_axis_tdata[15:0] < scfl_pkg::TABLE_DEPTH)
                    irr_mem[s_axis_tdata[15:0]] = s_axis_tdata[27:16];
            end
            if (m_axis_tvalid && m_axis_tready) begin
                got.data = m_axis_tdata;
                got.on = m_axis_tuser;
                if (expected_q.size() == 0) begin
                    $display("%0t: unexpected result word %h/%b", $time, got.data, got.on);
                    o_errors <= o_errors + 1;
                end else begin
                    want = expected_q.pop_front();
                    if (got !== want) begin
                        $display("%0t: mismatch irr exp %0d act %0d, raw exp %0d act %0d",
                                 $time, want.data[11:0], got.data[11:0],
                                 want.data[35:12], got.data[35:12]);
                        $display("%0t:   use exp %0d act %0d, flow exp %0d act %0d",
                                 $time, want.data[59:36], got.data[59:36],
                                 want.data[91:60], got.data[91:60]);
                        $display("%0t:   outlet exp %0d act %0d, pump exp %b act %b",
                                 $time, $signed(want.data[107:92]),
                                 $signed(got.data[107:92]), want.on, got.on);
                        o_errors <= o_errors + 1;
                    end
                end
            end
        end
    end
endmodule
`default_nettype wire

FILE: tb/tb.sv
// Testbench top for the solar collector flow limiter: stimulus and verdict.
`timescale 1ns / 100ps
`default_nettype none
module tb;
    logic         i_clk = 0;
    logic         i_rst_n = 0;
    logic         s_axis_tvalid = 0;
    logic         s_axis_tready;
    logic [47:0]  s_axis_tdata = '0;
    logic         s_axis_tuser = 0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 0;
    logic [111:0] m_axis_tdata;
    logic         m_axis_tuser;
    logic         i_cfg_we = 0;
    logic [scfl_pkg::CFG_IDX_W-1:0] i_cfg_addr = '0;
    logic [scfl_pkg::CFG_W-1:0]     i_cfg_data = '0;
    int           errors, pending;

    // loaded hour count; steps must only hit written entries
    int           loaded_len;
    bit           written [scfl_pkg::TABLE_DEPTH];

    always begin
        #2 i_clk = 1;
        #2 i_clk = 0;
    end

    solar_collector_flow_limiter_core dut (.*);

    scfl_checker chk (
        .i_clk, .i_rst_n, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
        .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser,
        .i_cfg_we, .i_cfg_addr, .i_cfg_data, .o_errors(errors), .o_pending(pending)
    );

    // sink: random stall per word, with a stall-free stretch mid run
    bit no_stall = 0;
    initial begin
        int gap;
        forever begin
            gap = no_stall ? 0 : $urandom_range(0, 7);
            repeat (gap) @(negedge i_clk) m_axis_tready <= 0;
            @(negedge i_clk) m_axis_tready <= 1;
            @(posedge i_clk);
            while (!m_axis_tvalid) @(posedge i_clk);
        end
    end

    task automatic cfg_write(scfl_pkg::t_cfg_idx idx, logic [31:0] val);
        @(negedge i_clk);
        i_cfg_we <= 1;
        i_cfg_addr <= idx;
        i_cfg_data <= val;
        @(negedge i_clk);
        i_cfg_we <= 0;
    endtask

    // one input word; source gap drawn per word
    task automatic send_word(bit step, logic [15:0] idx, logic [11:0] smp,
                             logic signed [15:0] tin, bit nogap);
        int gap;
        gap = nogap ? 0 : $urandom_range(0, 7);
        repeat (gap) @(negedge i_clk) s_axis_tvalid <= 0;
        @(negedge i_clk);
        s_axis_tvalid <= 1;
        s_axis_tuser <= step;
        s_axis_tdata <= {4'd0, tin, smp, idx};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        if (!step && idx < scfl_pkg::TABLE_DEPTH) written[idx] = 1;
    endtask

    task automatic idle_out();
        @(negedge i_clk) s_axis_tvalid <= 0;
        while (pending != 0) @(posedge i_clk);
        repeat (120) @(posedge i_clk);
    endtask

    // step on an hour whose slot is loaded
    task automatic send_step(logic signed [15:0] tin, bit nogap);
        logic [15:0] h;
        h = $urandom_range(0, 65535);
        while (loaded_len != 0 && !written[h % loaded_len]) h = $urandom_range(0, 65535);
        send_word(1, h, 0, tin, nogap);
    endtask

    task automatic load_table(int n, bit full_range);
        for (int a = 0; a < n; a++)
            send_word(0, a, full_range ? $urandom_range(0, 4095) : $urandom_range(0, 1200),
                      0, $urandom_range(0, 1));
    endtask

    initial begin
        logic [31:0] nom;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk) i_rst_n <= 1;

        // disabled block: table not loaded, any hour
        loaded_len = 0;
        send_word(1, 16'hFFFF, 0, 16'sh8000, 0);
        send_word(1, 0, 0, 16'sh7FFF, 0);
        // writes: extremes, and ignored out-of-range addresses
        send_word(0, 0, 12'hFFF, 0, 0);
        send_word(0, 1, 0, 16'sh8000, 0);
        send_word(0, 2, 12'd800, 16'sh7FFF, 0);
        send_word(0, 3, 12'd100, 0, 0);
        send_word(0, 16'hFFFF, 12'hABC, 0, 0);
        send_word(0, scfl_pkg::TABLE_DEPTH, 12'h555, 0, 0);
        idle_out();

        cfg_write(scfl_pkg::CFG_TABLE_LENGTH, 4);
        cfg_write(scfl_pkg::CFG_COLLECTOR_GAIN, 21'h1FFFFF);
        cfg_write(scfl_pkg::CFG_TURN_ON, 200);
        cfg_write(scfl_pkg::CFG_HEAT_CAPACITY, 0);
        cfg_write(scfl_pkg::CFG_NOMINAL_FLOW, 0);
        cfg_write(scfl_pkg::CFG_MAXIMUM_FLOW, 0);
        cfg_write(scfl_pkg::CFG_OUTLET_LIMIT, 16'd9000);
        cfg_write(scfl_pkg::CFG_RISE_LIMIT, 15'h7FFF);
        loaded_len = 4;
        for (int h = 0; h < 4; h++) send_word(1, h, 0, 16'sd2000, 0);
        send_word(1, 16'hFFFF, 0, 16'sh8000, 0);
        send_word(1, 2, 0, 16'sd9000, 0);   // inlet at limit
        send_word(1, 2, 0, 16'sh7FFF, 0);
        idle_out();

        cfg_write(scfl_pkg::CFG_COLLECTOR_GAIN, 0);
        cfg_write(scfl_pkg::CFG_OUTLET_LIMIT, 16'h8000);
        cfg_write(scfl_pkg::CFG_HEAT_CAPACITY, 16'hFFFF);
        cfg_write(scfl_pkg::CFG_NOMINAL_FLOW, 32'hFFFFFFFF);
        cfg_write(scfl_pkg::CFG_MAXIMUM_FLOW, 32'hFFFFFFFF);
        send_word(1, 0, 0, 16'sd100, 0);    // zero gain
        idle_out();
        cfg_write(scfl_pkg::CFG_COLLECTOR_GAIN, 1);
        cfg_write(scfl_pkg::CFG_TURN_ON, 0);
        cfg_write(scfl_pkg::CFG_OUTLET_LIMIT, 16'h7FFF);
        cfg_write(scfl_pkg::CFG_RISE_LIMIT, 0);
        send_word(1, 1, 0, 16'sd100, 0);    // zero irradiance, zero raw heat
        send_word(1, 3, 0, 16'sd100, 0);    // small irradiance, raw heat rounds to zero, huge flow
        idle_out();

        // random phases over several settings
        for (int ph = 0; ph < 12; ph++) begin
            cfg_write(scfl_pkg::CFG_TABLE_LENGTH,
                      (ph == 5) ? 15'h7FFF : $urandom_range(24, 64));
            cfg_write(scfl_pkg::CFG_COLLECTOR_GAIN,
                      (ph % 4 == 0) ? $urandom_range(0, 21'h1FFFFF)
                                    : $urandom_range(256, 4096));
            cfg_write(scfl_pkg::CFG_TURN_ON, (ph == 3) ? 4095 : $urandom_range(0, 300));
            cfg_write(scfl_pkg::CFG_HEAT_CAPACITY,
                      (ph == 7) ? 1 : $urandom_range(1000, 65535));
            nom = (ph == 8) ? $urandom : $urandom_range(1, 200000);
            cfg_write(scfl_pkg::CFG_NOMINAL_FLOW, nom);
            cfg_write(scfl_pkg::CFG_MAXIMUM_FLOW, $urandom_range(0, 3) == 0 ? nom / 2 :
                      (ph == 9 ? 32'hFFFFFFFF : nom + $urandom_range(0, 5000000)));
            cfg_write(scfl_pkg::CFG_OUTLET_LIMIT, $urandom_range(0, 3) == 0 ? 16'h7FFF :
                      (ph == 10 ? 16'h8000 : $urandom_range(3000, 12000)));
            cfg_write(scfl_pkg::CFG_RISE_LIMIT, $urandom_range(0, 2) == 0 ? 0 :
                      (ph == 11 ? 15'h7FFF : $urandom_range(1, 3000)));
            loaded_len = 0;
            for (int a = 0; a < scfl_pkg::TABLE_DEPTH; a++) written[a] = 0;
            load_table(64, ph == 3);
            if (ph == 5) begin
                // length beyond depth clamps to the full table
                loaded_len = scfl_pkg::TABLE_DEPTH;
            end else begin
                loaded_len = 64;
            end
            no_stall = (ph == 6);
            for (int k = 0; k < 60; k++) begin
                if ($urandom_range(0, 9) == 0)
                    send_word(0, $urandom_range(0, 65535), $urandom_range(0, 4095),
                              $urandom_range(0, 65535), no_stall);
                else
                    send_step($urandom_range(0, 3) == 0 ? $urandom_range(0, 65535)
                                                        : $urandom_range(0, 9000), no_stall);
            end
            no_stall = 0;
            idle_out();
            loaded_len = 0;
        end

        if (errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    initial begin
        #2ms;
        $display("[FAIL] regression broken");
        $finish;
    end
endmodule
`default_nettype wire
